[rtl/bpa_pkg.sv]
// ============================================================================
// bpa_pkg - shared types and constants for the buddy page allocator
// Field widths of the request and response items, operation and status codes,
// and the word geometry of the free-node bitmap.
// ============================================================================
`default_nettype none

package bpa_pkg;

    localparam int SIZE_W     = 21;
    localparam int OFFS_W     = 20;
    localparam int STAT_W     = 2;
    localparam int ORD_W      = 5;
    localparam int WORD_W     = 32;
    localparam int WORD_IDX_W = 5;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [OFFS_W-1:0] t_offs;
    typedef logic [STAT_W-1:0] t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_SIZE = 2'd1;
    localparam t_status ST_NO_BLOCK = 2'd2;

endpackage

`default_nettype wire

[rtl/bpa_ifs.sv]
// ============================================================================
// bpa_ifs - request and response channels of the buddy page allocator
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ============================================================================
`default_nettype none

interface bpa_req_if;
    logic           valid;
    logic           ready;
    logic           operation;
    bpa_pkg::t_size size_bytes;
    bpa_pkg::t_offs block_offset;

    modport source (output valid, output operation, output size_bytes,
                    output block_offset, input ready);
    modport sink   (input valid, input operation, input size_bytes,
                    input block_offset, output ready);
endinterface

interface bpa_rsp_if;
    logic             valid;
    logic             ready;
    bpa_pkg::t_offs   granted_offset;
    bpa_pkg::t_status status;

    modport source (output valid, output granted_offset, output status, input ready);
    modport sink   (input valid, input granted_offset, input status, output ready);
endinterface

`default_nettype wire

[rtl/bpa_ram.sv]
// ============================================================================
// bpa_ram - generic simple dual-port RAM
// One write port and one read port; read data is registered (old data on a
// same-address read during write).
// ============================================================================
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/buddy_page_allocator.sv]
// ============================================================================
// buddy_page_allocator - binary buddy allocator over 2^TOTAL_ORDER bytes
// Alloc scans the bitmap one word per cycle (at most 2^(LEVELS+1)/32 + 4 words),
//   then splits level by level down to the requested order; free reads the
//   stored order, then merges buddies level by level. One item at a time; the bitmap RAM port sets the pace.
// Reset: a clearing pass over every address of both RAMs rebuilds them; no
//   item is accepted until it ends.
// ============================================================================
`default_nettype none

module buddy_page_allocator #(
    parameter int PAGE_ORDER  = 12,
    parameter int TOTAL_ORDER = 20
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp
);

    localparam int LEVELS    = TOTAL_ORDER - PAGE_ORDER;
    localparam int NUM_PAGES = 1 << LEVELS;
    localparam int PIW       = (LEVELS > 0) ? LEVELS : 1;
    localparam int HW        = LEVELS + 1;
    localparam int WB        = bpa_pkg::WORD_IDX_W;
    localparam int WW        = bpa_pkg::WORD_W;
    localparam int OW        = bpa_pkg::OFFS_W;
    localparam int OrdW      = bpa_pkg::ORD_W;
    localparam int BW_DEPTH  = (HW > WB) ? (1 << (HW - WB)) : 1;
    localparam int BAW       = (HW > WB) ? (HW - WB) : 1;
    localparam int CLW       = (BAW > PIW) ? BAW : PIW;
    localparam int CLR_LAST  = ((BW_DEPTH > NUM_PAGES) ? BW_DEPTH : NUM_PAGES) - 1;
    localparam logic [OrdW-1:0] TOP_ORD = OrdW'(TOTAL_ORDER);
    localparam logic [OrdW-1:0] PG_ORD  = OrdW'(PAGE_ORDER);
    localparam logic [OrdW-1:0] LEV_K   = OrdW'(LEVELS);
    localparam longint unsigned REGION_BYTES = 64'd1 << TOTAL_ORDER;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_SP_RD, S_SP_WR, S_F_ORD, S_M_RD, S_M_CHK, S_OUT
    } t_state;

    // first and last bitmap word of the nodes at tree depth k
    function automatic logic [BAW-1:0] f_ws(input logic [OrdW-1:0] k);
        logic [31:0] t;
        t = 32'd1 << k;
        return BAW'(t >> WB);
    endfunction

    function automatic logic [BAW-1:0] f_we(input logic [OrdW-1:0] k);
        logic [31:0] t;
        t = (32'd2 << k) - 32'd1;
        return BAW'(t >> WB);
    endfunction

    // bits of a word that belong to depth k (only word 0 holds several depths)
    function automatic logic [WW-1:0] f_mask(input logic [OrdW-1:0] k);
        logic [WW-1:0] m;
        for (int i = 0; i < WW; i++) begin
            m[i] = (k >= OrdW'(WB)) || ((32'(i) >> k) == 32'd1);
        end
        return m;
    endfunction

    function automatic logic [WB-1:0] f_lsb(input logic [WW-1:0] v);
        logic [WB-1:0] r;
        r = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = WB'(i);
            end
        end
        return r;
    endfunction

    t_state r_state, n_state;
    logic [CLW-1:0]  r_clr, n_clr;
    logic [OrdW-1:0] r_need, n_need;
    logic [OrdW-1:0] r_ord, n_ord;
    logic [OrdW-1:0] r_ik, n_ik;
    logic [BAW-1:0]  r_iw, n_iw;
    logic            r_iv, n_iv;
    logic [OrdW-1:0] r_dk, n_dk;
    logic [BAW-1:0]  r_dw, n_dw;
    logic            r_dv, n_dv;
    logic [HW-1:0]   r_h, n_h;
    logic [PIW-1:0]  r_page, n_page;
    logic            r_first, n_first;
    bpa_pkg::t_offs   r_res_off, n_res_off;
    bpa_pkg::t_status r_res_st, n_res_st;
    logic             r_out_valid, n_out_valid;
    bpa_pkg::t_offs   r_out_off, n_out_off;
    bpa_pkg::t_status r_out_st, n_out_st;

    logic            bm_we;
    logic [BAW-1:0]  bm_waddr, bm_raddr;
    logic [WW-1:0]   bm_wdata, bm_rdata;
    logic            po_we;
    logic [PIW-1:0]  po_waddr, po_raddr;
    logic [OrdW-1:0] po_wdata, po_rdata;

    logic            size_bad;
    logic [OrdW-1:0] need_in;
    logic [PIW-1:0]  req_page;
    logic [WW-1:0]   dmask;
    logic            hit;
    logic [WB-1:0]   hit_bit;
    logic [HW-1:0]   hit_h;
    logic            iw_last;
    logic [HW-1:0]   sp_child;
    logic [BAW-1:0]  sp_word;
    logic [WB-1:0]   sp_bit;
    logic [OrdW-1:0] k_need;
    logic [HW-1:0]   al_pos;
    logic [31:0]     al_off;
    logic [PIW-1:0]  al_page;
    logic            fo_ok;
    logic [HW-1:0]   fr_h;
    logic [BAW-1:0]  mg_word;
    logic [WB-1:0]   mg_bit, mg_bud;

    bpa_ram #(.WIDTH(WW), .DEPTH(BW_DEPTH)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    bpa_ram #(.WIDTH(OrdW), .DEPTH(NUM_PAGES)) u_page_ord (
        .i_clk   (i_clk),
        .i_we    (po_we),
        .i_waddr (po_waddr),
        .i_wdata (po_wdata),
        .i_raddr (po_raddr),
        .o_rdata (po_rdata)
    );

    // request decode
    assign size_bad = (i_req.size_bytes == '0) || (64'(i_req.size_bytes) > REGION_BYTES);
    assign req_page = PIW'(32'(i_req.block_offset) >> PAGE_ORDER) & PIW'(NUM_PAGES - 1);

    always_comb begin
        need_in = PG_ORD;
        for (int i = PAGE_ORDER; i < TOTAL_ORDER; i++) begin
            if (64'(i_req.size_bytes) > (64'd1 << i)) begin
                need_in = OrdW'(i + 1);
            end
        end
    end

    // scan: word data comes back the cycle after its address is presented
    assign dmask   = f_mask(r_dk) & bm_rdata;
    assign hit     = r_dv && (dmask != '0);
    assign hit_bit = f_lsb(dmask);
    assign hit_h   = HW'({r_dw, hit_bit});
    assign iw_last = (r_iw == f_we(r_ik));

    // split: right child of the current node goes free
    assign sp_child = HW'({r_h, 1'b1});
    assign sp_word  = BAW'(sp_child >> WB);
    assign sp_bit   = WB'(sp_child);
    assign k_need   = TOP_ORD - r_need;
    assign al_pos   = r_h ^ (HW'(1) << k_need);
    assign al_off   = 32'(al_pos) << r_need;
    assign al_page  = PIW'(32'(al_pos) << (r_need - PG_ORD));

    // free: node of the stored order, then buddy merges
    assign fo_ok   = (po_rdata >= PG_ORD) && (po_rdata <= TOP_ORD);
    assign fr_h    = HW'(32'd1 << (TOP_ORD - po_rdata))
                   | HW'(32'(r_page) >> (po_rdata - PG_ORD));
    assign mg_word = BAW'(r_h >> WB);
    assign mg_bit  = WB'(r_h);
    assign mg_bud  = mg_bit ^ WB'(1);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_need      = r_need;
        n_ord       = r_ord;
        n_ik        = r_ik;
        n_iw        = r_iw;
        n_iv        = r_iv;
        n_dk        = r_dk;
        n_dw        = r_dw;
        n_dv        = r_dv;
        n_h         = r_h;
        n_page      = r_page;
        n_first     = r_first;
        n_res_off   = r_res_off;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid;
        n_out_off   = r_out_off;
        n_out_st    = r_out_st;
        bm_we       = 1'b0;
        bm_waddr    = r_dw;
        bm_wdata    = '0;
        bm_raddr    = r_iw;
        po_we       = 1'b0;
        po_waddr    = r_page;
        po_wdata    = '0;
        po_raddr    = r_page;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                bm_we    = 32'(r_clr) < 32'(BW_DEPTH);
                bm_waddr = BAW'(r_clr);
                bm_wdata = (r_clr == '0) ? WW'(2) : '0;
                po_we    = 32'(r_clr) < 32'(NUM_PAGES);
                po_waddr = PIW'(r_clr);
                po_wdata = (r_clr == '0) ? TOP_ORD : '0;
                if (r_clr == CLW'(CLR_LAST)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + CLW'(1);
                end
            end
            S_IDLE: begin
                po_raddr = req_page;
                if (i_req.valid) begin
                    if (i_req.operation == bpa_pkg::OP_FREE) begin
                        n_page  = req_page;
                        n_state = S_F_ORD;
                    end else if (size_bad) begin
                        n_res_off = '0;
                        n_res_st  = bpa_pkg::ST_BAD_SIZE;
                        n_state   = S_OUT;
                    end else begin
                        n_need  = need_in;
                        n_ik    = TOP_ORD - need_in;
                        n_iw    = f_ws(TOP_ORD - need_in);
                        n_iv    = 1'b1;
                        n_dv    = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                bm_raddr = r_iw;
                n_dv     = r_iv;
                n_dk     = r_ik;
                n_dw     = r_iw;
                if (r_iv) begin
                    if (iw_last) begin
                        if (r_ik == '0) begin
                            n_iv = 1'b0;
                        end else begin
                            n_ik = r_ik - OrdW'(1);
                            n_iw = f_ws(r_ik - OrdW'(1));
                        end
                    end else begin
                        n_iw = r_iw + BAW'(1);
                    end
                end
                if (hit) begin
                    // take the block, drop its free bit in the word at hand
                    bm_we    = 1'b1;
                    bm_waddr = r_dw;
                    bm_wdata = bm_rdata & ~(WW'(1) << hit_bit);
                    n_h      = hit_h;
                    n_ord    = TOP_ORD - r_dk;
                    n_state  = S_SP_RD;
                end else if (!r_dv && !r_iv) begin
                    n_res_off = '0;
                    n_res_st  = bpa_pkg::ST_NO_BLOCK;
                    n_state   = S_OUT;
                end
            end
            S_SP_RD: begin
                if (r_ord == r_need) begin
                    po_we     = 1'b1;
                    po_waddr  = al_page;
                    po_wdata  = r_need;
                    n_res_off = OW'(al_off);
                    n_res_st  = bpa_pkg::ST_OK;
                    n_state   = S_OUT;
                end else begin
                    bm_raddr = sp_word;
                    n_state  = S_SP_WR;
                end
            end
            S_SP_WR: begin
                bm_we    = 1'b1;
                bm_waddr = sp_word;
                bm_wdata = bm_rdata | (WW'(1) << sp_bit);
                n_h      = HW'({r_h, 1'b0});
                n_ord    = r_ord - OrdW'(1);
                n_state  = S_SP_RD;
            end
            S_F_ORD: begin
                n_res_off = '0;
                n_res_st  = bpa_pkg::ST_OK;
                if (fo_ok) begin
                    n_ord   = po_rdata;
                    n_h     = fr_h;
                    n_first = 1'b1;
                    n_state = S_M_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_M_RD: begin
                bm_raddr = mg_word;
                n_state  = S_M_CHK;
            end
            S_M_CHK: begin
                if (r_first && bm_rdata[mg_bit]) begin
                    // block already free: drop the request
                    n_state = S_OUT;
                end else begin
                    n_first = 1'b0;
                    if (r_first) begin
                        po_we    = 1'b1;
                        po_waddr = r_page;
                        po_wdata = '0;
                    end
                    bm_we    = 1'b1;
                    bm_waddr = mg_word;
                    if ((r_ord < TOP_ORD) && bm_rdata[mg_bud]) begin
                        bm_wdata = bm_rdata & ~(WW'(1) << mg_bud);
                        n_h      = r_h >> 1;
                        n_ord    = r_ord + OrdW'(1);
                        n_state  = S_M_RD;
                    end else begin
                        bm_wdata = bm_rdata | (WW'(1) << mg_bit);
                        n_state  = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_off   = r_res_off;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_iv        <= 1'b0;
            r_dv        <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_iv        <= n_iv;
            r_dv        <= n_dv;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
        r_need    <= n_need;
        r_ord     <= n_ord;
        r_ik      <= n_ik;
        r_iw      <= n_iw;
        r_dk      <= n_dk;
        r_dw      <= n_dw;
        r_h       <= n_h;
        r_page    <= n_page;
        r_res_off <= n_res_off;
        r_res_st  <= n_res_st;
        r_out_off <= n_out_off;
        r_out_st  <= n_out_st;
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.granted_offset = r_out_off;
    assign o_rsp.status         = r_out_st;

    a_scan_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_dv) |-> (r_dk <= LEV_K))
        else $error("scan data tagged beyond the tree depth");

    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SP_RD || r_state == S_SP_WR) |-> (r_ord >= r_need && r_ord <= TOP_ORD))
        else $error("split order outside the requested range");

    a_merge_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M_RD) |-> ((32'(r_h) >> (TOP_ORD - r_ord)) == 32'd1))
        else $error("merge node does not belong to its order");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("response loaded outside the output state");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("response pending during the clearing pass");

endmodule

`default_nettype wire

[tb/buddy_page_allocator_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// buddy_page_allocator_tb - self-checking bench for the buddy page allocator
// Walks a directed table of allocate and free items, then a long random mix
// of allocations, frees of live blocks, and noise. A behavioral copy of the
// buddy tree or a typed row's own result predicts each response; a scoreboard checks them in order.
// ============================================================================

module buddy_page_allocator_tb;

    localparam int PG_ORD     = 12;
    localparam int TOT_ORD    = 20;
    localparam int N_PAGES    = 1 << (TOT_ORD - PG_ORD);
    localparam int N_NODES    = 2 * N_PAGES - 1;
    localparam int DIR_N      = 25;
    localparam int RAND_N     = 700;
    localparam int CALM_TAIL  = 100;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 64;

    typedef struct packed {
        bpa_pkg::t_offs   offs;
        bpa_pkg::t_status status;
    } t_grant;

    typedef struct packed {
        logic             op;
        bpa_pkg::t_size   size;
        bpa_pkg::t_offs   offs;
        logic             typed;
        bpa_pkg::t_offs   exp_offs;
        bpa_pkg::t_status exp_status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    // buddy tree mirror: one free bit per node, block order per heading page
    bit       node_free [N_NODES];
    bit [4:0] page_order [N_PAGES];

    t_grant         grant_q [$];
    bpa_pkg::t_offs live_q [$];
    t_row           dir_tab [DIR_N];
    bit             idle_on;
    int             err_cnt;
    int             n_granted, n_bad_size, n_no_block, n_frees;

    function automatic int node_idx(int ord, int pos);
        return ((1 << (TOT_ORD - ord)) - 1) + pos;
    endfunction

    function automatic void tree_clear();
        foreach (node_free[i]) node_free[i] = 1'b0;
        foreach (page_order[i]) page_order[i] = '0;
        node_free[0]  = 1'b1;
        page_order[0] = 5'(TOT_ORD);
    endfunction

    function automatic t_grant tree_alloc(bpa_pkg::t_size size);
        t_grant g;
        int     need;
        int     ord;
        int     pos;
        int     o;
        int     p;
        bit     found;
        g = '{offs: '0, status: bpa_pkg::ST_NO_BLOCK};
        found = 1'b0;
        if (size == 0 || size > (1 << TOT_ORD)) begin
            g.status = bpa_pkg::ST_BAD_SIZE;
            return g;
        end
        need = PG_ORD;
        while (need < TOT_ORD && (1 << need) < size)
            need++;
        for (ord = need; ord <= TOT_ORD && !found; ord++) begin
            for (pos = 0; pos < (1 << (TOT_ORD - ord)) && !found; pos++) begin
                if (node_free[node_idx(ord, pos)]) begin
                    found = 1'b1;
                    node_free[node_idx(ord, pos)] = 1'b0;
                    o = ord;
                    p = pos;
                    // split down, leaving each right half free
                    while (o > need) begin
                        o--;
                        p = p << 1;
                        node_free[node_idx(o, p + 1)] = 1'b1;
                    end
                    g.offs   = bpa_pkg::t_offs'(p << need);
                    g.status = bpa_pkg::ST_OK;
                    page_order[g.offs[TOT_ORD-1:PG_ORD]] = 5'(need);
                end
            end
        end
        return g;
    endfunction

    function automatic void tree_release(bpa_pkg::t_offs offs);
        int page;
        int ord;
        int pos;
        page = int'(offs[TOT_ORD-1:PG_ORD]);
        ord  = int'(page_order[page]);
        if (ord < PG_ORD || ord > TOT_ORD)
            return;
        pos = page >> (ord - PG_ORD);
        // drop double frees and pages that head nothing
        if (node_free[node_idx(ord, pos)])
            return;
        page_order[page] = '0;
        while (ord < TOT_ORD && node_free[node_idx(ord, pos ^ 1)]) begin
            node_free[node_idx(ord, pos ^ 1)] = 1'b0;
            pos = pos >> 1;
            ord++;
        end
        node_free[node_idx(ord, pos)] = 1'b1;
    endfunction

    function automatic t_grant tree_step(logic op, bpa_pkg::t_size size,
                                         bpa_pkg::t_offs offs);
        t_grant g;
        g = '{offs: '0, status: bpa_pkg::ST_OK};
        if (op == bpa_pkg::OP_ALLOC) begin
            g = tree_alloc(size);
        end else begin
            tree_release(offs);
        end
        return g;
    endfunction

    task automatic send_item(input logic op, input bpa_pkg::t_size size,
                             input bpa_pkg::t_offs offs,
                             input logic typed, input t_grant typed_val);
        t_grant g;
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.size_bytes   <= size;
        req_ch.block_offset <= offs;
        do @(posedge i_clk); while (!req_ch.ready);
        g = tree_step(op, size, offs);
        if (op == bpa_pkg::OP_FREE) n_frees++;
        else if (g.status == bpa_pkg::ST_OK) n_granted++;
        else if (g.status == bpa_pkg::ST_BAD_SIZE) n_bad_size++;
        else n_no_block++;
        if (op == bpa_pkg::OP_ALLOC && g.status == bpa_pkg::ST_OK)
            live_q.push_back(g.offs);
        grant_q.push_back(typed ? typed_val : g);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (grant_q.size() != 0)
            @(posedge i_clk);
    endtask

    // response side: random stalls and the in-order scoreboard
    initial begin : rsp_side
        int     stall_left;
        t_grant want;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected response: granted_offset %h status %0d",
                           rsp_ch.granted_offset, rsp_ch.status);
                    err_cnt++;
                end else begin
                    want = grant_q.pop_front();
                    if (rsp_ch.granted_offset !== want.offs) begin
                        $error("granted_offset: expected %h, got %h",
                               want.offs, rsp_ch.granted_offset);
                        err_cnt++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp_ch.status);
                        err_cnt++;
                    end
                end
            end
            if (stall_left != 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_MAX) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_MAX);
        $display("FAILURE");
        $finish;
    end

    initial begin : stim
        int             k;
        int             r;
        int             ord;
        int             w;
        logic           op;
        bpa_pkg::t_size size;
        bpa_pkg::t_offs offs;
        t_grant         nil;

        nil = '{offs: '0, status: bpa_pkg::ST_OK};
        err_cnt = 0;
        n_granted = 0;
        n_bad_size = 0;
        n_no_block = 0;
        n_frees = 0;
        idle_on = 1'b1;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= bpa_pkg::OP_ALLOC;
        req_ch.size_bytes   <= '0;
        req_ch.block_offset <= '0;
        tree_clear();

        dir_tab = '{
            '{bpa_pkg::OP_ALLOC, 21'h000000, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_BAD_SIZE},
            '{bpa_pkg::OP_ALLOC, 21'h1FFFFF, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_BAD_SIZE},
            '{bpa_pkg::OP_ALLOC, 21'h100001, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_BAD_SIZE},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h1FFFFF, 20'hFFFFF, 1'b1, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h100000, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h000001, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_NO_BLOCK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h00ABC, 1'b1, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h000001, 20'h00000, 1'b1, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h001000, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h001001, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h080000, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h040001, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h040000, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h01FFF, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h02000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h80000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h40000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h0FFFFF, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_ALLOC, 21'h000FFF, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'hFF000, 1'b0, 20'h00000, bpa_pkg::ST_OK},
            '{bpa_pkg::OP_FREE,  21'h000000, 20'h00000, 1'b0, 20'h00000, bpa_pkg::ST_OK}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            sender_gap();
            send_item(dir_tab[i].op, dir_tab[i].size, dir_tab[i].offs, dir_tab[i].typed,
                      '{offs: dir_tab[i].exp_offs, status: dir_tab[i].exp_status});
        end
        req_ch.valid <= 1'b0;
        wait_drained();
        live_q.delete();

        for (k = 0; k < RAND_N; k++) begin
            if (k >= RAND_N - CALM_TAIL)
                idle_on = 1'b0;
            else if (k % 32 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            // hold off until the pipe is empty now and then
            if (k % 150 == 75) begin
                req_ch.valid <= 1'b0;
                wait_drained();
            end
            sender_gap();
            r = $urandom_range(0, 99);
            size = '0;
            offs = '0;
            if (r < 8) begin
                op   = 1'($urandom);
                size = bpa_pkg::t_size'($urandom);
                offs = bpa_pkg::t_offs'($urandom);
            end else if (r < 12) begin
                op   = bpa_pkg::OP_ALLOC;
                size = $urandom_range(0, 1)
                     ? bpa_pkg::t_size'(0)
                     : bpa_pkg::t_size'($urandom_range(21'h100001, 21'h1FFFFF));
            end else if (live_q.size() != 0 && (r < 55 || live_q.size() > 40)) begin
                op = bpa_pkg::OP_FREE;
                w  = $urandom_range(0, live_q.size() - 1);
                offs = live_q[w];
                live_q.delete(w);
                if ($urandom_range(0, 1) != 0)
                    offs = offs | bpa_pkg::t_offs'($urandom_range(0, 4095));
            end else begin
                op = bpa_pkg::OP_ALLOC;
                w  = $urandom_range(0, 99);
                if (w < 60)      ord = PG_ORD;
                else if (w < 85) ord = $urandom_range(13, 15);
                else if (w < 97) ord = $urandom_range(16, 18);
                else             ord = $urandom_range(19, 20);
                if (ord == PG_ORD)
                    size = bpa_pkg::t_size'($urandom_range(1, 1 << PG_ORD));
                else
                    size = bpa_pkg::t_size'($urandom_range((1 << (ord - 1)) + 1, 1 << ord));
                offs = bpa_pkg::t_offs'($urandom);
            end
            send_item(op, size, offs, 1'b0, nil);
        end

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d grants, %0d bad sizes, %0d full-region misses, %0d frees",
                 n_granted, n_bad_size, n_no_block, n_frees);
        $display("including double frees, unaligned offsets and whole-region blocks");
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
